// ----- rtl/core/flg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flanger shared definitions
// Register map, fixed-point constants and sine table build constants.
// ----------------------------------------------------------------------------
package flg_pkg;

  localparam int PADDR_W = 5;
  localparam int REG_SEL_W = 3;

  localparam logic [REG_SEL_W-1:0] REG_WET_GAIN      = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_BASE_DELAY    = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_DEPTH         = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_PHASE_STEP    = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_DRY_DELAYED   = 3'd5;

  // multiplier coefficient operand: signed Q2.15 gains up to 32768
  localparam int MAC_B_W = 17;

  localparam int Q15_ONE    = 32768;
  localparam int ROUND_HALF = 16384;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

endpackage

// ----- rtl/core/flg_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flanger multiply-accumulate unit
// Registered signed a*b + c, shared by every product of one item.
// ----------------------------------------------------------------------------
module flg_mac #(
  parameter int A_W = 25
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [A_W-1:0]                   a,
  input  logic signed [flg_pkg::MAC_B_W-1:0]      b,
  input  logic signed [A_W+flg_pkg::MAC_B_W-1:0]  c,
  output logic signed [A_W+flg_pkg::MAC_B_W-1:0]  acc
);
  import flg_pkg::*;

  localparam int ACC_W = A_W + MAC_B_W;

  logic signed [ACC_W-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= prod + c;
    end
  end

endmodule

// ----- rtl/core/flanger_delay_effect.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flanger delay effect
// LFO-modulated delay tap mixed with a direct or delayed dry path.
// ----------------------------------------------------------------------------
// Each item runs through the sine, depth, delay, tap, feedback, write and mix
// states to a result in the output register, held in done while an earlier
// result is still waiting there; in_ready is high only while the sequencer is
// idle. Its steps come from the single multiply-accumulate unit, which forms in
// turn the LFO depth product, the feedback sum and the dry and wet mix terms,
// and by the registered reads of the delay and dry memories. The memories are
// not cleared: a wrap flag per memory marks entries not yet written since
// reset, and these read as zero, so the block takes items right after reset.
// ----------------------------------------------------------------------------
module flanger_delay_effect #(
  parameter int DELAY_DEPTH      = 1024,
  parameter int DRY_DEPTH        = 1024,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS      = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [flg_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     sample_out
);
  import flg_pkg::*;

  localparam int DLY_AW = $clog2(DELAY_DEPTH);
  localparam int DRY_AW = (DRY_DEPTH > 1) ? $clog2(DRY_DEPTH) : 1;
  localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int A_W    = SAMPLE_BITS + 1;
  localparam int ACC_W  = A_W + MAC_B_W;
  localparam int DCMP_W = (DLY_AW + 1 > 11) ? DLY_AW + 1 : 11;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SINE  = 9'b000000010,
    S_DEPTH = 9'b000000100,
    S_DELAY = 9'b000001000,
    S_TAP   = 9'b000010000,
    S_FBK   = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_MIXW  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      t = Q30_ONE - (((x2 * t) / TAYLOR_DIV[i]) >> 30);
    end
    s = (x * t) >> 30;
    s = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-16:0] s;
    logic [SAMPLE_BITS-1:0]   r;
    s = v[ACC_W-1:15];
    if ((&s[ACC_W-16:SAMPLE_BITS-1]) || ~(|s[ACC_W-16:SAMPLE_BITS-1])) begin
      r = s[SAMPLE_BITS-1:0];
    end else if (s[ACC_W-16]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration registers
  logic [15:0] wet_gain;
  logic [14:0] feedback_gain;
  logic [9:0]  base_delay_samples;
  logic [9:0]  depth_samples;
  logic [30:0] phase_step;
  logic        dry_delayed;

  logic                 cfg_wr;
  logic [REG_SEL_W-1:0] cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_gain           <= 16'd16384;
      feedback_gain      <= 15'd16384;
      base_delay_samples <= 10'd256;
      depth_samples      <= 10'd128;
      phase_step         <= 31'd89478;
      dry_delayed        <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_WET_GAIN:      wet_gain           <= pwdata[15:0];
        REG_FEEDBACK_GAIN: feedback_gain      <= pwdata[14:0];
        REG_BASE_DELAY:    base_delay_samples <= pwdata[9:0];
        REG_DEPTH:         depth_samples      <= pwdata[9:0];
        REG_PHASE_STEP:    phase_step         <= pwdata[30:0];
        REG_DRY_DELAYED:   dry_delayed        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WET_GAIN:      prdata = {16'd0, wet_gain};
      REG_FEEDBACK_GAIN: prdata = {17'd0, feedback_gain};
      REG_BASE_DELAY:    prdata = {22'd0, base_delay_samples};
      REG_DEPTH:         prdata = {22'd0, depth_samples};
      REG_PHASE_STEP:    prdata = {1'b0, phase_step};
      REG_DRY_DELAYED:   prdata = {31'd0, dry_delayed};
      default:           prdata = 32'd0;
    endcase
  end

  // sine table
  logic [14:0] sine_rom [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    assign sine_rom[k] = sine_entry(k);
  end

  // datapath state
  state_t state;
  state_t state_next;

  logic [31:0]                    lfo_phase;
  logic [DLY_AW-1:0]              write_pointer;
  logic [DRY_AW-1:0]              dry_pointer;
  logic                           delay_full;
  logic                           dry_full;

  logic signed [SAMPLE_BITS-1:0]  x_q;
  logic [1:0]                     quad_q;
  logic [SIN_AW-1:0]              idx_q;
  logic [14:0]                    sine_q;
  logic signed [SAMPLE_BITS-1:0]  dry_rd;
  logic signed [SAMPLE_BITS-1:0]  tap_rd;
  logic                           tap_ok;
  logic [DLY_AW-1:0]              d_q;

  logic delay_ring_we;
  logic signed [SAMPLE_BITS-1:0]  delay_ring [DELAY_DEPTH];
  logic signed [SAMPLE_BITS-1:0]  dry_ring [DRY_DEPTH];

  logic [30+SIN_AW-1:0]           idx_prod;
  logic [SIN_AW-1:0]              sine_addr;
  logic signed [11:0]             d_raw;
  logic [DCMP_W-1:0]              d_pos;
  logic [DLY_AW-1:0]              d_clamp;
  logic [DLY_AW:0]                rp_sum;
  logic [DLY_AW-1:0]              rp;
  logic                           tap_ok_next;
  logic signed [SAMPLE_BITS-1:0]  tap;
  logic signed [SAMPLE_BITS-1:0]  dry;
  logic [16:0]                    wet_sat;
  logic [16:0]                    dry_gain;
  logic signed [SAMPLE_BITS-1:0]  fb_val;

  logic                           mac_en;
  logic signed [A_W-1:0]          mac_a;
  logic signed [MAC_B_W-1:0]      mac_b;
  logic signed [ACC_W-1:0]        mac_c;
  logic signed [ACC_W-1:0]        acc;

  flg_mac #(
    .A_W (A_W)
  ) u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .acc (acc)
  );

  assign in_ready = (state == S_IDLE);

  assign idx_prod  = (30 + SIN_AW)'(lfo_phase[29:0]) * (30 + SIN_AW)'(SINE_TABLE_DEPTH);
  assign sine_addr = quad_q[0] ? SIN_AW'(SINE_TABLE_DEPTH) - idx_q : idx_q;

  assign d_raw   = $signed({2'b00, base_delay_samples}) + $signed(acc[26:15]);
  assign d_pos   = DCMP_W'(d_raw[10:0]);
  assign d_clamp = d_raw[11] ? '0 :
                   (d_pos > DCMP_W'(DELAY_DEPTH - 1)) ? DLY_AW'(DELAY_DEPTH - 1) :
                   d_pos[DLY_AW-1:0];

  assign rp_sum = {1'b0, write_pointer} + (DLY_AW + 1)'(DELAY_DEPTH) - {1'b0, d_q};
  assign rp     = (rp_sum >= (DLY_AW + 1)'(DELAY_DEPTH)) ?
                  DLY_AW'(rp_sum - (DLY_AW + 1)'(DELAY_DEPTH)) : rp_sum[DLY_AW-1:0];
  // entry not yet written since reset reads as zero
  assign tap_ok_next = delay_full || ((d_q != '0) && (d_q <= write_pointer));

  assign tap      = tap_ok ? tap_rd : '0;
  assign dry      = dry_delayed ? (dry_full ? dry_rd : '0) : x_q;
  assign wet_sat  = (wet_gain > 16'(Q15_ONE)) ? 17'(Q15_ONE) : {1'b0, wet_gain};
  assign dry_gain = 17'(Q15_ONE) - wet_sat;
  assign fb_val   = sat_round(acc);

  always_comb begin
    mac_en = 1'b0;
    mac_a  = '0;
    mac_b  = '0;
    mac_c  = ACC_W'(ROUND_HALF);
    case (state)
      S_DEPTH: begin
        mac_en = 1'b1;
        mac_a  = $signed({{(A_W-10){1'b0}}, depth_samples});
        mac_b  = quad_q[1] ? -$signed({2'b00, sine_q}) : $signed({2'b00, sine_q});
      end
      S_FBK: begin
        mac_en = 1'b1;
        mac_a  = A_W'(tap);
        mac_b  = $signed({2'b00, feedback_gain});
        mac_c  = (ACC_W'(x_q) <<< 15) + ACC_W'(ROUND_HALF);
      end
      S_WRITE: begin
        mac_en = 1'b1;
        mac_a  = A_W'(dry);
        mac_b  = $signed(dry_gain);
      end
      S_MIXW: begin
        mac_en = 1'b1;
        mac_a  = A_W'(tap);
        mac_b  = $signed(wet_sat);
        mac_c  = acc;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_SINE;
      S_SINE:  state_next = S_DEPTH;
      S_DEPTH: state_next = S_DELAY;
      S_DELAY: state_next = S_TAP;
      S_TAP:   state_next = S_FBK;
      S_FBK:   state_next = S_WRITE;
      S_WRITE: state_next = S_MIXW;
      S_MIXW:  state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign delay_ring_we = (state == S_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lfo_phase     <= '0;
      write_pointer <= '0;
      dry_pointer   <= '0;
      delay_full    <= 1'b0;
      dry_full      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        lfo_phase <= lfo_phase + {1'b0, phase_step};
      end
      if (delay_ring_we) begin
        if (write_pointer == DLY_AW'(DELAY_DEPTH - 1)) begin
          write_pointer <= '0;
          delay_full    <= 1'b1;
        end else begin
          write_pointer <= write_pointer + DLY_AW'(1);
        end
        if (dry_delayed) begin
          if (dry_pointer == DRY_AW'(DRY_DEPTH - 1)) begin
            dry_pointer <= '0;
            dry_full    <= 1'b1;
          end else begin
            dry_pointer <= dry_pointer + DRY_AW'(1);
          end
        end
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_q    <= sample_in;
      quad_q <= lfo_phase[31:30];
      idx_q  <= idx_prod[30+SIN_AW-1:30];
    end
    if (state == S_SINE) begin
      sine_q <= sine_rom[sine_addr];
    end
    if (state == S_DELAY) begin
      d_q <= d_clamp;
    end
    if (state == S_TAP) begin
      tap_ok <= tap_ok_next;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      sample_out <= sat_round(acc);
    end
  end

  // delay memory: read tap, write feedback value
  always_ff @(posedge clk) begin
    if (state == S_TAP) begin
      tap_rd <= delay_ring[rp];
    end
    if (delay_ring_we) begin
      delay_ring[write_pointer] <= fb_val;
    end
  end

  // dry memory: read oldest item, replace with current input
  always_ff @(posedge clk) begin
    if (state == S_SINE) begin
      dry_rd <= dry_ring[dry_pointer];
    end
    if (delay_ring_we && dry_delayed) begin
      dry_ring[dry_pointer] <= x_q;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SINE))
    else $error("accepted item did not start the sequence");

  a_wp_only_on_write: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> $stable(write_pointer))
    else $error("write pointer moved outside the write step");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    delay_full |=> delay_full)
    else $error("delay memory wrap flag cleared");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result shown without finishing an item");
`endif

endmodule
